[src/nphf_pkg.sv]
// Shared types, constants and controller/datapath interface structs for the neighbor pair finder.
package nphf_pkg;

  // Store sizing. Indices are six bits wide; capacity is capped at the store depth.
  localparam int MAX_POINTS  = 64;
  localparam int STORE_DEPTH = 64;
  localparam int CAPACITY    = (MAX_POINTS < STORE_DEPTH) ? MAX_POINTS : STORE_DEPTH;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = IDX_W + 1;

  // Configuration register indexes.
  localparam logic [1:0] REG_BOND_DIST = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_HOP_AMP   = 2'd2;

  // Configuration reset values.
  localparam logic [14:0] BOND_RESET = 15'd256;
  localparam logic [15:0] TOL_RESET  = 16'd655;
  localparam logic [15:0] HOP_RESET  = 16'd256;

  // One input point.
  typedef struct packed {
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               first_point;
  } point_in_t;

  // One result item.
  typedef struct packed {
    logic [IDX_W-1:0]   row_index;
    logic [IDX_W-1:0]   col_index;
    logic signed [15:0] hop_value;
    logic               pair_found;
    logic               dropped;
    logic               last_result;
  } result_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUT,
    ST_SQUARE,
    ST_SCAN,
    ST_FLUSH,
    ST_DROP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic calc_cut;
    logic calc_sq;
    logic issue;
    logic flush_emit;
    logic drop_emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic adv;
    logic scan_done;
    logic pipe_empty;
  } dp_status_t;

endpackage

[src/nphf_ctrl.sv]
// Controller state machine sequencing cutoff setup, store scan, flush or drop.
module nphf_ctrl import nphf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       point_valid,
  output logic       point_stall,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_next  = state;
    cmd         = '0;
    point_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        point_stall = 1'b0;
        if (point_valid) begin
          cmd.accept = 1'b1;
          state_next = status.full ? ST_DROP : ST_CUT;
        end
      end
      ST_CUT: begin
        cmd.calc_cut = 1'b1;
        state_next   = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.calc_sq = 1'b1;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_FLUSH;
        end else begin
          cmd.issue = status.adv;
        end
      end
      ST_FLUSH: begin
        if (status.pipe_empty && status.adv) begin
          cmd.flush_emit = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DROP: begin
        if (status.adv) begin
          cmd.drop_emit = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/nphf_datapath.sv]
// Datapath: configuration registers, point store, distance pipeline and result register.
module nphf_datapath import nphf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  point_in_t  point_data,
  output result_t    result_data,
  output logic       result_valid,
  input  logic       result_stall,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status
);

  // Configuration registers.
  logic [14:0] bond_dist;
  logic [15:0] tolerance_fraction;
  logic [15:0] hop_amplitude;

  // Point store and bookkeeping.
  logic [31:0]      store [STORE_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cnt_eff;
  logic [IDX_W-1:0] col;
  logic [CNT_W-1:0] rd_ptr;
  logic [15:0]      px;
  logic [15:0]      py;

  // Cutoff.
  logic [16:0] tol_plus;
  logic [31:0] cut_prod;
  logic [31:0] cut;
  logic [63:0] cut_sq;
  logic [31:0] cut2_hi;

  // Pipeline stages.
  logic             adv;
  logic             s1_v;
  logic [IDX_W-1:0] s1_row;
  logic [31:0]      s1_pt;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic             s2_v;
  logic [IDX_W-1:0] s2_row;
  logic [31:0]      sq_x;
  logic [31:0]      sq_y;
  logic [32:0]      r2;
  logic             match;

  // Pending pair, held back until it is known whether it is the last one.
  logic             pend_v;
  logic [IDX_W-1:0] pend_row;

  // Result register.
  logic    out_load;
  result_t result_next;

  assign cfg_ready = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      bond_dist          <= BOND_RESET;
      tolerance_fraction <= TOL_RESET;
      hop_amplitude      <= HOP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BOND_DIST: bond_dist          <= cfg_data[14:0];
        REG_TOLERANCE: tolerance_fraction <= cfg_data;
        REG_HOP_AMP:   hop_amplitude      <= cfg_data;
        default: ;
      endcase
    end
  end

  // A first point restarts the set, so it never sees a full store.
  always_comb begin
    cnt_eff = point_data.first_point ? '0 : count;
  end

  assign adv               = !result_valid || !result_stall;
  assign status.full       = (cnt_eff >= CNT_W'(CAPACITY));
  assign status.adv        = adv;
  assign status.scan_done  = (rd_ptr == {1'b0, col});
  assign status.pipe_empty = !s1_v && !s2_v;

  // Point count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept && !status.full) begin
      count <= cnt_eff + CNT_W'(1);
    end
  end

  // Capture the new point and store it at its index.
  always_ff @(posedge clk) begin
    if (cmd.accept && !status.full) begin
      store[cnt_eff[IDX_W-1:0]] <= {point_data.coord_y, point_data.coord_x};
      col <= cnt_eff[IDX_W-1:0];
      px  <= point_data.coord_x;
      py  <= point_data.coord_y;
    end
  end

  // Scan read pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
    end else if (cmd.accept) begin
      rd_ptr <= '0;
    end else if (cmd.issue) begin
      rd_ptr <= rd_ptr + CNT_W'(1);
    end
  end

  // Squared cutoff, built in two multiply steps after each point is stored.
  assign tol_plus = {1'b0, tolerance_fraction} + 17'h10000;
  assign cut_prod = 32'(bond_dist) * 32'(tol_plus);
  assign cut_sq   = 64'(cut) * 64'(cut);

  always_ff @(posedge clk) begin
    if (cmd.calc_cut) begin
      cut <= cut_prod;
    end
    if (cmd.calc_sq) begin
      cut2_hi <= cut_sq[63:32];
    end
  end

  // Stage one: registered store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_pt  <= store[rd_ptr[IDX_W-1:0]];
      s1_row <= rd_ptr[IDX_W-1:0];
    end
  end

  // Stage two: coordinate differences squared.
  assign dx    = $signed({s1_pt[15], s1_pt[15:0]}) - $signed({px[15], px});
  assign dy    = $signed({s1_pt[31], s1_pt[31:16]}) - $signed({py[15], py});
  assign dx_sq = 34'(dx) * 34'(dx);
  assign dy_sq = 34'(dy) * 34'(dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x   <= dx_sq[31:0];
      sq_y   <= dy_sq[31:0];
      s2_row <= s1_row;
    end
  end

  // Compare: integer r2 against the upper (integer) half of the Q.32 squared cutoff.
  assign r2    = {1'b0, sq_x} + {1'b0, sq_y};
  assign match = s2_v && (r2 <= {1'b0, cut2_hi});

  // Pending pair register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
    end else if (adv && match) begin
      pend_v <= 1'b1;
    end else if (cmd.flush_emit) begin
      pend_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && match) begin
      pend_row <= s2_row;
    end
  end

  // Result selection.
  always_comb begin
    out_load    = 1'b0;
    result_next = '0;
    if (cmd.drop_emit) begin
      out_load                = 1'b1;
      result_next.dropped     = 1'b1;
      result_next.last_result = 1'b1;
    end else if (cmd.flush_emit) begin
      out_load                = 1'b1;
      result_next.col_index   = col;
      result_next.last_result = 1'b1;
      if (pend_v) begin
        result_next.row_index  = pend_row;
        result_next.hop_value  = hop_amplitude;
        result_next.pair_found = 1'b1;
      end
    end else if (adv && match && pend_v) begin
      out_load               = 1'b1;
      result_next.row_index  = pend_row;
      result_next.col_index  = col;
      result_next.hop_value  = hop_amplitude;
      result_next.pair_found = 1'b1;
    end
  end

  // Result register; a transfer frees it for the next load.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result_data <= result_next;
    end
  end

endmodule

[src/neighbor_pair_hopping_finder_top.sv]
// Top level of the fixed-radius neighbor pair finder.
//
// Points enter on the point channel (point_valid/point_stall/point_data); a
// transfer happens when valid is high and stall is low. first_point restarts
// the set. Each new point j is compared with the stored points 0..j-1, and
// every pair within (bond * (1 + tolerance))^2 leaves on the result channel
// as (row i, col j, hop value), ordered by i. A point with no neighbor gives
// one result with pair_found low; a point arriving at a full store (64
// points) gives one result with dropped high. last_result marks the final
// result of each point.
// Sequence: without back-pressure a point passes through an accept state, the
// cutoff multiply and squaring states, j store reads at one per cycle plus a
// state that sees the scan end, the drain of the read/square/compare
// pipeline, and a flush state. A dropped point goes from the accept state to
// a drop state. The next point is taken while the last result still waits in
// the output register. A stalled receiver freezes the scan pipeline in place;
// nothing is lost. Configuration is written on cfg_valid/cfg_ready (always
// ready) by the user only while idle; the block does not enforce this.
// Synchronous reset empties the store count and loads the register defaults;
// store contents are not cleared.
module neighbor_pair_hopping_finder_top import nphf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       point_valid,
  output logic       point_stall,
  input  point_in_t  point_data,
  output logic       result_valid,
  input  logic       result_stall,
  output result_t    result_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  nphf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .status      (status),
    .cmd         (cmd)
  );

  // Store, arithmetic and result register.
  nphf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .point_data   (point_data),
    .result_data  (result_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

[test/tb_neighbor_pair_hopping_finder_top.sv]
// Self-checking testbench for the fixed-radius neighbor pair finder.
module tb_neighbor_pair_hopping_finder_top;
  import nphf_pkg::*;

  // Holds the point set and register copies, and predicts the pair list of each point.
  class pair_list_checker;
    logic [14:0]        bond_len  = BOND_RESET;
    logic [15:0]        tol_frac  = TOL_RESET;
    logic signed [15:0] hop_amp   = HOP_RESET;
    logic [31:0]        point_words[CAPACITY];
    int unsigned        stored    = 0;
    result_t            pairs_due[$];
    int                 errors    = 0;

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      unique case (idx)
        REG_BOND_DIST: bond_len = data[14:0];
        REG_TOLERANCE: tol_frac = data;
        REG_HOP_AMP:   hop_amp  = data;
        default: ;
      endcase
    endfunction

    // Exact test: squared distance against the squared cutoff, both taken to Q.32.
    function bit in_reach(logic [31:0] a, logic [31:0] b);
      longint     dx, dy;
      logic [63:0] r2, reach, reach2;
      dx = longint'($signed(a[15:0])) - longint'($signed(b[15:0]));
      dy = longint'($signed(a[31:16])) - longint'($signed(b[31:16]));
      r2 = dx * dx + dy * dy;
      reach = 64'(bond_len) * (64'd65536 + 64'(tol_frac));
      reach2 = reach * reach;
      if (r2 >= 64'h1_0000_0000) return 1'b0;
      return (r2 << 32) <= reach2;
    endfunction

    // Called for every accepted point; queues the results it must cause.
    function void take_point(point_in_t p);
      logic [31:0] word;
      result_t     r;
      result_t     fresh[$];
      int unsigned j;
      word = {p.coord_y, p.coord_x};
      if (p.first_point) stored = 0;
      r = '0;
      // A full store discards the point and reports it once.
      if (stored >= CAPACITY) begin
        r.dropped = 1'b1;
        r.last_result = 1'b1;
        pairs_due.push_back(r);
        return;
      end
      j = stored;
      for (int unsigned i = 0; i < j; i++) begin
        if (in_reach(point_words[i], word)) begin
          r = '0;
          r.row_index = i[IDX_W-1:0];
          r.col_index = j[IDX_W-1:0];
          r.hop_value = hop_amp;
          r.pair_found = 1'b1;
          fresh.push_back(r);
        end
      end
      point_words[j] = word;
      stored = j + 1;
      // A lonely point still gives one result carrying its own index.
      if (fresh.size() == 0) begin
        r = '0;
        r.col_index = j[IDX_W-1:0];
        fresh.push_back(r);
      end
      r = fresh[fresh.size() - 1];
      r.last_result = 1'b1;
      fresh[fresh.size() - 1] = r;
      foreach (fresh[k]) pairs_due.push_back(fresh[k]);
    endfunction

    // Compares one accepted result with the oldest prediction.
    function void check_result(result_t got);
      result_t want;
      if (pairs_due.size() == 0) begin
        $error("unexpected result: row_index %0d col_index %0d", got.row_index,
               got.col_index);
        errors++;
        return;
      end
      want = pairs_due.pop_front();
      if (got.row_index !== want.row_index) begin
        $error("row_index: expected %0d, actual %0d", want.row_index, got.row_index);
        errors++;
      end
      if (got.col_index !== want.col_index) begin
        $error("col_index: expected %0d, actual %0d", want.col_index, got.col_index);
        errors++;
      end
      if (got.hop_value !== want.hop_value) begin
        $error("hop_value: expected %0d, actual %0d", want.hop_value, got.hop_value);
        errors++;
      end
      if (got.pair_found !== want.pair_found) begin
        $error("pair_found: expected %0b, actual %0b", want.pair_found, got.pair_found);
        errors++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped: expected %0b, actual %0b", want.dropped, got.dropped);
        errors++;
      end
      if (got.last_result !== want.last_result) begin
        $error("last_result: expected %0b, actual %0b", want.last_result,
               got.last_result);
        errors++;
      end
    endfunction
  endclass

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        point_valid = 1'b0;
  logic        point_stall;
  point_in_t   point_data = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_BOND_DIST;
  logic [15:0] cfg_data = '0;

  pair_list_checker sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int items_sent = 0;

  neighbor_pair_hopping_finder_top dut (
    .clk          (clk),
    .rst          (rst),
    .point_valid  (point_valid),
    .point_stall  (point_stall),
    .point_data   (point_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) sb.check_result(result_data);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run after a long stretch without any transfer.
  initial begin
    int quiet;
    quiet = 0;
    do begin
      @(posedge clk);
      if ((point_valid && !point_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end while (quiet < QUIET_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic signed [15:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic point_in_t pt(int x, int y, bit first);
    point_in_t p;
    p.coord_x = 16'(x);
    p.coord_y = 16'(y);
    p.first_point = first;
    return p;
  endfunction

  // Offers one point, with random idle cycles ahead of it, until a transfer.
  task automatic send_point(point_in_t p);
    if ($urandom_range(99) < send_idle_pct) begin
      point_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    point_valid <= 1'b1;
    point_data <= p;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    sb.take_point(p);
    items_sent++;
  endtask

  // Stops offering points and waits until every predicted result has arrived.
  task automatic drain;
    point_valid <= 1'b0;
    while (sb.pairs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes all three registers once the block has gone idle.
  task automatic configure(logic [15:0] bond, logic [15:0] tol, logic [15:0] hop);
    logic [1:0]  idx[3];
    logic [15:0] val[3];
    idx = '{REG_BOND_DIST, REG_TOLERANCE, REG_HOP_AMP};
    val = '{bond, tol, hop};
    drain();
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // A new set laid on a 4x4 grid at the bond spacing, jittered around the cutoff.
  task automatic send_lattice_set(int n);
    int step, jr, ox, oy;
    step = (sb.bond_len == 0) ? 1 : int'(sb.bond_len);
    jr = step / 32 + 1;
    ox = int'($urandom_range(40000)) - 20000;
    oy = int'($urandom_range(40000)) - 20000;
    for (int k = 0; k < n; k++) begin
      point_in_t p;
      p.coord_x = clamp16(ox + int'($urandom_range(3)) * step +
                          int'($urandom_range(2 * jr)) - jr);
      p.coord_y = clamp16(oy + int'($urandom_range(3)) * step +
                          int'($urandom_range(2 * jr)) - jr);
      p.first_point = (k == 0);
      send_point(p);
    end
  endtask

  // Mostly well-formed sets; the rest are full-range points that may restart a set.
  task automatic run_random(int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(99) < 10) send_lattice_set($urandom_range(40, 66));
        else send_lattice_set($urandom_range(2, 10));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          point_in_t p;
          p.coord_x = 16'($urandom);
          p.coord_y = 16'($urandom);
          p.first_point = ($urandom_range(7) == 0);
          send_point(p);
        end
      end
    end
  endtask

  function automatic logic [15:0] random_bond();
    return 16'($urandom_range(64, 2048)) | (16'($urandom_range(1)) << 15);
  endfunction

  initial begin
    int ox, oy;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: a pair exactly on the axis, one just inside and one just
    // outside the cutoff, the coordinate extremes, and a duplicate corner.
    send_point(pt(0, 0, 1));
    send_point(pt(256, 0, 0));
    send_point(pt(0, 258, 0));
    send_point(pt(0, -259, 0));
    send_point(pt(32767, 32767, 0));
    send_point(pt(-32768, -32768, 0));
    send_point(pt(32767, -32768, 0));
    send_point(pt(-32768, 32767, 0));
    send_point(pt(-32768, -32768, 0));

    // Largest cutoff, with the unused top bit of the bond write set; the span
    // between opposite corners still falls outside.
    configure(16'hFFFF, 16'hFFFF, 16'h8000);
    send_point(pt(-32768, -32768, 1));
    send_point(pt(32767, -32768, 0));
    send_point(pt(32767, 32767, 0));
    send_point(pt(0, 0, 0));
    send_point(pt(-32768, 32767, 0));

    // Zero cutoff: only coincident points pair.
    configure(16'h0000, 16'h0000, 16'h7FFF);
    send_point(pt(100, -100, 1));
    send_point(pt(100, -100, 0));
    send_point(pt(101, -100, 0));
    send_point(pt(100, -100, 0));

    // Reset-like settings, no idling, and a long receiver hold-off to back up the input.
    configure(16'd256, 16'd655, 16'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = HOLD_CYCLES;
    run_random(33);

    configure(random_bond(), 16'($urandom_range(32767)), 16'($urandom));
    send_idle_pct = 68;
    recv_stall_pct = 0;
    run_random(33);

    configure(random_bond(), 16'($urandom_range(32767)), 16'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 68;
    run_random(33);

    configure(random_bond(), 16'($urandom), 16'($urandom));
    send_idle_pct = 26;
    recv_stall_pct = 26;
    run_random(33);

    configure(random_bond(), 16'h0000, 16'($urandom));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(33);

    // One tight cluster fills the store so the last point pairs with all others,
    // then overflow drops, and a restart on the full store.
    configure(16'h7FFF, 16'($urandom), 16'($urandom));
    send_idle_pct = 26;
    recv_stall_pct = 26;
    ox = int'($urandom_range(40000)) - 20000;
    oy = int'($urandom_range(40000)) - 20000;
    for (int k = 0; k < CAPACITY + 2; k++) begin
      point_in_t p;
      p.coord_x = clamp16(ox + int'($urandom_range(8192)) - 4096);
      p.coord_y = clamp16(oy + int'($urandom_range(8192)) - 4096);
      p.first_point = (k == 0);
      send_point(p);
    end
    send_point(pt(ox, oy, 1));
    send_point(pt(ox + 1, oy - 1, 0));

    drain();
    repeat (40) @(posedge clk);
    if (sb.pairs_due.size() != 0) begin
      $error("%0d expected results never arrived", sb.pairs_due.size());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
